// File: hw/rtl/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg: shared types and constants for the positional PID unit
// Field widths, accumulator widths, register indexes and sequencer codes.
// ----------------------------------------------------------------------------
package ppid_pkg;

	// Field and register widths
	localparam int SAMPLE_W  = 16;
	localparam int ERR_W     = SAMPLE_W + 1;
	localparam int DELTA_W   = ERR_W + 1;
	localparam int GAIN_W    = 24;
	localparam int FRAC_W    = 16;
	localparam int WEIGHT_W  = 17;
	localparam int LIMIT_W   = 32;
	localparam int DRIVE_W   = 32;
	localparam int SUM_W     = 32;
	localparam int DER_W     = 34;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	// Shared multiplier: signed 25 x signed 18
	localparam int MUL_A_W = GAIN_W + 1;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int SPLIT   = MUL_B_W - 1;

	// Accumulators: filter / derivative term, and output sum
	localparam int FACC_W = 60;
	localparam int OACC_W = 58;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << 16;
	localparam logic [FACC_W-1:0]   FACC_HALF  = FACC_W'(1) << (FRAC_W - 1);
	localparam logic [OACC_W-1:0]   OACC_HALF  = OACC_W'(1) << (FRAC_W - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P        = 3'd0,
		REG_GAIN_I        = 3'd1,
		REG_GAIN_D        = 3'd2,
		REG_FILTER_WEIGHT = 3'd3,
		REG_UPPER_LIMIT   = 3'd4,
		REG_LOWER_LIMIT   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// Sequencer steps: F_HI to I_HI each issue one product, which is folded into an accumulator at the next step
	typedef enum logic [3:0] {
		STEP_INTEG = 4'd0,
		STEP_F_HI  = 4'd1,
		STEP_F_LO  = 4'd2,
		STEP_F_K   = 4'd3,
		STEP_P     = 4'd4,
		STEP_D_HI  = 4'd5,
		STEP_D_LO  = 4'd6,
		STEP_I_LO  = 4'd7,
		STEP_I_HI  = 4'd8,
		STEP_I_ACC = 4'd9,
		STEP_D_ADD = 4'd10,
		STEP_OUT   = 4'd11
	} step_t;

endpackage

// File: hw/rtl/positional_pid_filtered_derivative_unit.sv
// ----------------------------------------------------------------------------
// positional_pid_filtered_derivative_unit: fixed-point positional PID
// Takes no new input transfer until the result is committed: the twelve sequencer
// steps share the single 25x18 multiplier, and the unit returns to idle to take the
// next transfer. A stalled drive holds the last step.
// Async reset loads the register defaults and clears integral and history.
// ----------------------------------------------------------------------------
module positional_pid_filtered_derivative_unit import ppid_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] setpoint,
	input  logic signed [SAMPLE_W-1:0] feedback,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [DRIVE_W-1:0]  drive,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	// Control and configuration
	state_t                     state_q;
	step_t                      step_q;
	logic                       out_valid_q;
	logic [GAIN_W-1:0]          gain_p_q;
	logic [GAIN_W-1:0]          gain_i_q;
	logic [GAIN_W-1:0]          gain_d_q;
	logic [WEIGHT_W-1:0]        weight_q;
	logic signed [LIMIT_W-1:0]  upper_q;
	logic signed [LIMIT_W-1:0]  lower_q;

	// Controller history
	logic signed [SUM_W-1:0]    error_sum_q;
	logic signed [ERR_W-1:0]    prior_error_q;
	logic signed [DER_W-1:0]    prior_der_q;
	logic signed [DRIVE_W-1:0]  prior_drive_q;

	// Working registers
	logic signed [ERR_W-1:0]    err_q;
	logic signed [DELTA_W-1:0]  delta_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [FACC_W-1:0]   facc_q;
	logic signed [OACC_W-1:0]   oacc_q;
	logic signed [DRIVE_W-1:0]  drive_q;

	logic                       in_xfer;
	logic                       commit;
	logic [WEIGHT_W-1:0]        k_w;
	logic [WEIGHT_W-1:0]        k_rest;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [FACC_W-1:0]   prod_f;
	logic signed [OACC_W-1:0]   prod_o;
	logic signed [DER_W-1:0]    der_new;
	logic                       add_err;
	logic signed [SUM_W:0]      sum_ext;
	logic signed [SUM_W-1:0]    sum_sat;
	logic signed [OACC_W-1:0]   oacc_shift;
	logic signed [DRIVE_W-1:0]  drive_sat;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign commit    = (state_q == ST_RUN) && (step_q == STEP_OUT) && (!out_valid_q || out_ready);

	// Clamp filter weight to one
	assign k_w    = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	assign k_rest = WEIGHT_ONE - k_w;

	// Filtered derivative sits in the upper part of the filter accumulator
	assign der_new = facc_q[DER_W+FRAC_W-1:FRAC_W];

	// Anti-windup gate and saturating integral
	always_comb begin
		if (prior_drive_q >= upper_q) begin
			add_err = err_q[ERR_W-1];
		end else if (prior_drive_q <= lower_q) begin
			add_err = !err_q[ERR_W-1] && (err_q != '0);
		end else begin
			add_err = 1'b1;
		end
		sum_ext = {error_sum_q[SUM_W-1], error_sum_q}
			+ {{(SUM_W+1-ERR_W){err_q[ERR_W-1]}}, err_q};
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
	end

	// Select multiplier operands for the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			STEP_F_HI: begin
				mul_a = {{(MUL_A_W-WEIGHT_W){1'b0}}, k_rest};
				mul_b = {prior_der_q[DER_W-1], prior_der_q[DER_W-1:SPLIT]};
			end
			STEP_F_LO: begin
				mul_a = {{(MUL_A_W-WEIGHT_W){1'b0}}, k_rest};
				mul_b = {1'b0, prior_der_q[SPLIT-1:0]};
			end
			STEP_F_K: begin
				mul_a = {{(MUL_A_W-WEIGHT_W){1'b0}}, k_w};
				mul_b = delta_q;
			end
			STEP_P: begin
				mul_a = {1'b0, gain_p_q};
				mul_b = {err_q[ERR_W-1], err_q};
			end
			STEP_D_HI: begin
				mul_a = {1'b0, gain_d_q};
				mul_b = {der_new[DER_W-1], der_new[DER_W-1:SPLIT]};
			end
			STEP_D_LO: begin
				mul_a = {1'b0, gain_d_q};
				mul_b = {1'b0, prior_der_q[SPLIT-1:0]};
			end
			STEP_I_LO: begin
				mul_a = {1'b0, gain_i_q};
				mul_b = {1'b0, error_sum_q[SPLIT-1:0]};
			end
			STEP_I_HI: begin
				mul_a = {1'b0, gain_i_q};
				mul_b = {{(MUL_B_W-SUM_W+SPLIT){error_sum_q[SUM_W-1]}},
					error_sum_q[SUM_W-1:SPLIT]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod   = mul_a * mul_b;
	assign prod_f = {{(FACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign prod_o = {{(OACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	// Round output sum to integer and saturate
	always_comb begin
		oacc_shift = oacc_q >>> FRAC_W;
		if (oacc_shift[OACC_W-1:DRIVE_W-1] != {(OACC_W-DRIVE_W+1){oacc_shift[OACC_W-1]}}) begin
			drive_sat = oacc_shift[OACC_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
				: {1'b0, {(DRIVE_W-1){1'b1}}};
		end else begin
			drive_sat = oacc_shift[DRIVE_W-1:0];
		end
	end

	// Sequencer, configuration and controller history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= STEP_INTEG;
			out_valid_q   <= 1'b0;
			gain_p_q      <= GAIN_W'(1310720);
			gain_i_q      <= '0;
			gain_d_q      <= GAIN_W'(65536);
			weight_q      <= WEIGHT_W'(32768);
			upper_q       <= LIMIT_W'(10000);
			lower_q       <= -LIMIT_W'(10000);
			error_sum_q   <= '0;
			prior_error_q <= '0;
			prior_der_q   <= '0;
			prior_drive_q <= '0;
		end else begin
			// Register writes
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_GAIN_P:        gain_p_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_I:        gain_i_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_D:        gain_d_q <= cfg_data[GAIN_W-1:0];
					REG_FILTER_WEIGHT: weight_q <= cfg_data[WEIGHT_W-1:0];
					REG_UPPER_LIMIT:   upper_q  <= cfg_data[LIMIT_W-1:0];
					REG_LOWER_LIMIT:   lower_q  <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end

			// Drop output valid once the result transfers
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_RUN;
						step_q  <= STEP_INTEG;
					end
				end
				ST_RUN: begin
					if (step_q == STEP_INTEG) begin
						if (add_err) begin
							error_sum_q <= sum_sat;
						end
						prior_error_q <= err_q;
					end
					if (step_q == STEP_D_HI) begin
						prior_der_q <= der_new;
					end
					if (step_q == STEP_OUT) begin
						// Hold in the last step until the output register is free
						if (commit) begin
							out_valid_q   <= 1'b1;
							prior_drive_q <= drive_sat;
							state_q       <= ST_IDLE;
						end
					end else begin
						step_q <= step_t'(step_q + 4'd1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod;
		if (in_xfer) begin
			err_q <= ERR_W'(setpoint) - ERR_W'(feedback);
		end
		if (commit) begin
			drive_q <= drive_sat;
		end
		if (state_q == ST_RUN) begin
			case (step_q)
				STEP_INTEG: begin
					delta_q <= {err_q[ERR_W-1], err_q} - {prior_error_q[ERR_W-1], prior_error_q};
				end
				STEP_F_LO: begin
					facc_q <= (prod_f <<< SPLIT) | FACC_HALF;
				end
				STEP_F_K: begin
					facc_q <= facc_q + prod_f;
				end
				STEP_P: begin
					facc_q <= facc_q + (prod_f <<< FRAC_W);
				end
				STEP_D_HI: begin
					oacc_q <= prod_o + OACC_HALF;
				end
				STEP_D_LO: begin
					facc_q <= (prod_f <<< SPLIT) | FACC_HALF;
				end
				STEP_I_LO: begin
					facc_q <= facc_q + prod_f;
				end
				STEP_I_HI: begin
					oacc_q <= oacc_q + prod_o;
				end
				STEP_I_ACC: begin
					oacc_q <= oacc_q + (prod_o <<< SPLIT);
				end
				STEP_D_ADD: begin
					oacc_q <= oacc_q + OACC_W'(facc_q >>> FRAC_W);
				end
				default: ;
			endcase
		end
	end

endmodule
